/* src/rbsi_pkg.sv */
// shared types, constants and a saturation helper for the ray box slab intersect unit
`default_nettype none
package rbsi_pkg;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int DIV_STEPS = 2 * CW;

  // narrowest face-bias test value; 0.001 rounded to the nearest lsb
  localparam logic [CW-1:0] FACE_BIAS = CW'(((64'd1 << FB) + 64'd500) / 64'd1000);

  localparam logic [2:0] FACE_NONE = 3'd0;

  typedef struct packed {
    logic signed [CW-1:0] ray_origin_x;
    logic signed [CW-1:0] ray_origin_y;
    logic signed [CW-1:0] ray_origin_z;
    logic signed [CW-1:0] ray_dir_x;
    logic signed [CW-1:0] ray_dir_y;
    logic signed [CW-1:0] ray_dir_z;
  } ray_in_t;

  typedef struct packed {
    logic                 hit;
    logic        [CW-2:0] hit_distance;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic signed [CW-1:0] hit_z;
    logic        [2:0]    face;
  } ray_out_t;

  // per-ray work item, all three axes, carried from the front to the back
  typedef struct packed {
    logic                 miss;
    logic signed [CW+1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
    logic signed [CW-1:0] org_x, org_y, org_z;
    logic signed [CW-1:0] dir_x, dir_y, dir_z;
  } rbsi_job_t;

  // saturate a wide signed value to the coordinate range
  function automatic logic signed [CW-1:0] sat_coord(input logic signed [2*CW+1:0] v);
    logic signed [2*CW+1:0] mx;
    logic signed [2*CW+1:0] mn;
    begin
      mx = (2*CW+2)'({1'b0, {(CW-1){1'b1}}});
      mn = -mx - (2*CW+2)'(1);
      if (v > mx) sat_coord = mx[CW-1:0];
      else if (v < mn) sat_coord = mn[CW-1:0];
      else sat_coord = v[CW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

/* src/rbsi_front.sv */
// front: box bounds, zero-direction slab check and job formation
`default_nettype none
module rbsi_front
  import rbsi_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic signed [CW-1:0] ctr_x,
  input  wire logic signed [CW-1:0] ctr_y,
  input  wire logic signed [CW-1:0] ctr_z,
  input  wire logic        [CW-2:0] size_x,
  input  wire logic        [CW-2:0] size_y,
  input  wire logic        [CW-2:0] size_z,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ray_in_t              in_data,
  output logic                      job_valid,
  input  wire logic                 job_ready,
  output rbsi_job_t                 job
);

  logic      job_valid_r;
  rbsi_job_t job_r;
  rbsi_job_t job_nxt;
  logic signed [CW+1:0] lx, hx, ly, hy, lz, hz;
  logic zx, zy, zz;

  always_comb begin
    lx = (CW+2)'(ctr_x) - (CW+2)'({1'b0, size_x} >> 1);
    hx = (CW+2)'(ctr_x) + (CW+2)'({1'b0, size_x} >> 1);
    ly = (CW+2)'(ctr_y) - (CW+2)'({1'b0, size_y} >> 1);
    hy = (CW+2)'(ctr_y) + (CW+2)'({1'b0, size_y} >> 1);
    lz = (CW+2)'(ctr_z) - (CW+2)'({1'b0, size_z} >> 1);
    hz = (CW+2)'(ctr_z) + (CW+2)'({1'b0, size_z} >> 1);
    zx = (in_data.ray_dir_x == '0) &&
         ((CW+2)'(in_data.ray_origin_x) < lx || (CW+2)'(in_data.ray_origin_x) > hx);
    zy = (in_data.ray_dir_y == '0) &&
         ((CW+2)'(in_data.ray_origin_y) < ly || (CW+2)'(in_data.ray_origin_y) > hy);
    zz = (in_data.ray_dir_z == '0) &&
         ((CW+2)'(in_data.ray_origin_z) < lz || (CW+2)'(in_data.ray_origin_z) > hz);
    job_nxt.miss = zx | zy | zz;
    job_nxt.lo_x = lx; job_nxt.hi_x = hx;
    job_nxt.lo_y = ly; job_nxt.hi_y = hy;
    job_nxt.lo_z = lz; job_nxt.hi_z = hz;
    job_nxt.org_x = in_data.ray_origin_x;
    job_nxt.org_y = in_data.ray_origin_y;
    job_nxt.org_z = in_data.ray_origin_z;
    job_nxt.dir_x = in_data.ray_dir_x;
    job_nxt.dir_y = in_data.ray_dir_y;
    job_nxt.dir_z = in_data.ray_dir_z;
  end

  assign in_ready  = !job_valid_r || job_ready;
  assign job_valid = job_valid_r;
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (in_ready) begin
      job_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      job_r <= job_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/rbsi_fifo.sv */
// short queue between front and back
`default_nettype none
module rbsi_fifo
  import rbsi_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  wire rbsi_job_t wr_data,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output rbsi_job_t      rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rbsi_job_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr_fire, rd_fire;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_fire) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
      if (rd_fire) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr_fire) - (AW+1)'(rd_fire);
    end
    if (wr_fire) mem_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

/* src/rbsi_div.sv */
// pipelined restoring divider: one quotient bit per stage, saturated signed result
`default_nettype none
module rbsi_div
  import rbsi_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CW+1:0] num,
  input  wire logic signed [CW-1:0] den,
  output logic signed [CW-1:0]      quo
);

  localparam int NW = CW + 2 + FB;  // numerator magnitude width
  localparam int NS = NW;

  logic [NW-1:0] n_r [NS+1];
  logic [NW-1:0] q_r [NS+1];
  logic [CW:0]   r_r [NS+1];
  logic [CW-1:0] d_r [NS+1];
  logic          s_r [NS+1];

  logic [CW+1:0] nmag;
  logic [CW-1:0] dmag;
  logic signed [NW+1:0] qs;
  logic signed [NW+1:0] mx;

  assign nmag = num[CW+1] ? (CW+2)'(-num) : num;
  assign dmag = den[CW-1] ? CW'(-den) : den;

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0] <= {nmag, {FB{1'b0}}};
      q_r[0] <= '0;
      r_r[0] <= '0;
      d_r[0] <= dmag;
      s_r[0] <= num[CW+1] ^ den[CW-1];
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [CW+1:0] t;
    assign t = {r_r[i], n_r[i][NW-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i+1] <= n_r[i] << 1;
        d_r[i+1] <= d_r[i];
        s_r[i+1] <= s_r[i];
        if (t >= (CW+2)'(d_r[i])) begin
          r_r[i+1] <= (CW+1)'(t - (CW+2)'(d_r[i]));
          q_r[i+1] <= {q_r[i][NW-2:0], 1'b1};
        end else begin
          r_r[i+1] <= t[CW:0];
          q_r[i+1] <= {q_r[i][NW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    mx = (NW+2)'({1'b0, {(CW-1){1'b1}}});
    qs = s_r[NS] ? -(NW+2)'(q_r[NS]) : (NW+2)'(q_r[NS]);
    if (qs > mx) quo = mx[CW-1:0];
    else if (qs < -mx - (NW+2)'(1)) quo = {1'b1, {(CW-1){1'b0}}};
    else quo = qs[CW-1:0];
  end

endmodule
`default_nettype wire

/* src/rbsi_back.sv */
// back: slab divisions, interval narrowing, hit point and face, output register
`default_nettype none
module rbsi_back
  import rbsi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      job_valid,
  output logic           job_ready,
  input  wire rbsi_job_t job,
  output logic           out_valid,
  input  wire logic      out_ready,
  output ray_out_t       out_data
);

  localparam int DL = CW + 2 + FB + 1;  // job delay-line depth, matched to the divider pipeline
  localparam int PL = DL + 3;            // valid stages ahead of the output register

  // the whole pipe advances together; stall when output is held
  logic adv;
  logic v_r [PL];
  rbsi_job_t jd_r [DL];
  logic signed [CW-1:0] q [6];

  logic out_valid_r;
  ray_out_t out_r;

  assign adv       = !out_valid_r || out_ready;
  assign job_ready = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  rbsi_div u_dlx (.clk, .en(adv), .num(job.lo_x - (CW+2)'(job.org_x)), .den(job.dir_x), .quo(q[0]));
  rbsi_div u_dhx (.clk, .en(adv), .num(job.hi_x - (CW+2)'(job.org_x)), .den(job.dir_x), .quo(q[1]));
  rbsi_div u_dly (.clk, .en(adv), .num(job.lo_y - (CW+2)'(job.org_y)), .den(job.dir_y), .quo(q[2]));
  rbsi_div u_dhy (.clk, .en(adv), .num(job.hi_y - (CW+2)'(job.org_y)), .den(job.dir_y), .quo(q[3]));
  rbsi_div u_dlz (.clk, .en(adv), .num(job.lo_z - (CW+2)'(job.org_z)), .den(job.dir_z), .quo(q[4]));
  rbsi_div u_dhz (.clk, .en(adv), .num(job.hi_z - (CW+2)'(job.org_z)), .den(job.dir_z), .quo(q[5]));

  always_ff @(posedge clk) begin
    if (adv) begin
      jd_r[0] <= job;
      for (int i = 1; i < DL; i++) jd_r[i] <= jd_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PL; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= job_valid;
      for (int i = 1; i < PL; i++) v_r[i] <= v_r[i-1];
    end
  end

  // stage a: interval narrowing
  rbsi_job_t j_a;
  logic signed [CW:0] tlo, thi;
  logic miss_a;
  assign j_a = jd_r[DL-1];
  always_comb begin
    logic signed [CW:0] t0, t1;
    logic signed [CW-1:0] dd;
    tlo = '0;
    thi = (CW+1)'({1'b0, {(CW-1){1'b1}}});
    for (int a = 0; a < 3; a++) begin
      dd = (a == 0) ? j_a.dir_x : (a == 1) ? j_a.dir_y : j_a.dir_z;
      t0 = dd[CW-1] ? (CW+1)'(q[2*a+1]) : (CW+1)'(q[2*a]);
      t1 = dd[CW-1] ? (CW+1)'(q[2*a]) : (CW+1)'(q[2*a+1]);
      if (dd != '0) begin
        if (t0 > tlo) tlo = t0;
        if (t1 < thi) thi = t1;
      end
    end
    miss_a = j_a.miss || (thi < tlo);
  end

  rbsi_job_t j_b;
  logic miss_b;
  logic [CW-2:0] t_b;
  always_ff @(posedge clk) begin
    if (adv) begin
      j_b    <= j_a;
      miss_b <= miss_a;
      t_b    <= tlo[CW-2:0];
    end
  end

  // stage b: products t * dir
  logic signed [2*CW:0] p_x, p_y, p_z;
  rbsi_job_t j_c;
  logic miss_c;
  logic [CW-2:0] t_c;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_x <= $signed({1'b0, t_b}) * j_b.dir_x;
      p_y <= $signed({1'b0, t_b}) * j_b.dir_y;
      p_z <= $signed({1'b0, t_b}) * j_b.dir_z;
      j_c <= j_b; miss_c <= miss_b; t_c <= t_b;
    end
  end

  // stage c: floor scale, add origin, saturate
  logic signed [CW-1:0] hx_d, hy_d, hz_d;
  rbsi_job_t j_d;
  logic miss_d;
  logic [CW-2:0] t_d;
  always_ff @(posedge clk) begin
    if (adv) begin
      hx_d <= sat_coord((2*CW+2)'(j_c.org_x) + (2*CW+2)'(p_x >>> FB));
      hy_d <= sat_coord((2*CW+2)'(j_c.org_y) + (2*CW+2)'(p_y >>> FB));
      hz_d <= sat_coord((2*CW+2)'(j_c.org_z) + (2*CW+2)'(p_z >>> FB));
      j_d <= j_c; miss_d <= miss_c; t_d <= t_c;
    end
  end

  // stage d: face pick
  logic [2:0] face_d;
  always_comb begin
    logic signed [CW+2:0] dv [6];
    logic near [6];
    logic signed [CW+2:0] bias;
    bias = $signed((CW+3)'(FACE_BIAS));
    dv[0] = (CW+3)'(hx_d) - (CW+3)'(j_d.lo_x);
    dv[1] = (CW+3)'(hx_d) - (CW+3)'(j_d.hi_x);
    dv[2] = (CW+3)'(hy_d) - (CW+3)'(j_d.lo_y);
    dv[3] = (CW+3)'(hy_d) - (CW+3)'(j_d.hi_y);
    dv[4] = (CW+3)'(hz_d) - (CW+3)'(j_d.lo_z);
    dv[5] = (CW+3)'(hz_d) - (CW+3)'(j_d.hi_z);
    for (int k = 0; k < 6; k++)
      near[k] = (dv[k] < bias) && (dv[k] > -bias);
    face_d = FACE_NONE;
    for (int k = 5; k >= 0; k--)
      if (near[k]) face_d = 3'(k + 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[PL-1];
    end
    if (adv) begin
      if (miss_d) begin
        out_r <= '0;
      end else begin
        out_r.hit          <= 1'b1;
        out_r.hit_distance <= t_d;
        out_r.hit_x        <= hx_d;
        out_r.hit_y        <= hy_d;
        out_r.hit_z        <= hz_d;
        out_r.face         <= face_d;
      end
    end
  end

endmodule
`default_nettype wire

/* src/ray_box_slab_intersect_unit.sv */
// top level: config registers, front classifier, job queue and slab back end
`default_nettype none
// Ray against axis-aligned box by the slab method, signed Q16.16 coordinates.
// One ray is accepted per cycle when the result side keeps up; each ray passes
// through the front register and the queue, then through the back end: the six
// bit-per-stage dividers (one per slab plane), then narrowing, the hit-point
// multiply and the face pick. A four-entry queue decouples front and back.
// Box registers are written over the APB port at 4*index; the user must write
// them only while idle, as the block itself does not enforce it.
module ray_box_slab_intersect_unit
  import rbsi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire ray_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output ray_out_t         out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [2:0] REG_CX = 3'd0, REG_CY = 3'd1, REG_CZ = 3'd2;
  localparam logic [2:0] REG_SX = 3'd3, REG_SY = 3'd4, REG_SZ = 3'd5;

  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic [CW-2:0] sx_r, sy_r, sz_r;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; cz_r <= '0;
      sx_r <= '0; sy_r <= '0; sz_r <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (ridx)
        REG_CX: cx_r <= pwdata;
        REG_CY: cy_r <= pwdata;
        REG_CZ: cz_r <= pwdata;
        REG_SX: sx_r <= pwdata[CW-2:0];
        REG_SY: sy_r <= pwdata[CW-2:0];
        REG_SZ: sz_r <= pwdata[CW-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_CX: prdata = cx_r;
      REG_CY: prdata = cy_r;
      REG_CZ: prdata = cz_r;
      REG_SX: prdata = {1'b0, sx_r};
      REG_SY: prdata = {1'b0, sy_r};
      REG_SZ: prdata = {1'b0, sz_r};
      default: prdata = '0;
    endcase
  end

  logic fj_valid, fj_ready, bj_valid, bj_ready;
  rbsi_job_t fj, bj;

  rbsi_front u_front (
    .clk, .rst_n,
    .ctr_x(cx_r), .ctr_y(cy_r), .ctr_z(cz_r),
    .size_x(sx_r), .size_y(sy_r), .size_z(sz_r),
    .in_valid, .in_ready, .in_data,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  rbsi_fifo #(.DEPTH(4)) u_fifo (
    .clk, .rst_n,
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  rbsi_back u_back (
    .clk, .rst_n,
    .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_valid, .out_ready, .out_data
  );

endmodule
`default_nettype wire
